>>> src/mas_pkg.sv
package mas_pkg;

  // item operations
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_ERRORS = 2'd1,
    OP_FORCE      = 2'd2,
    OP_SET_ENABLE = 2'd3
  } op_t;

  // tracking algorithms
  typedef enum logic [2:0] {
    ALG_SWEEP    = 3'd0,
    ALG_PEO      = 3'd1,
    ALG_DYN_STEP = 3'd2,
    ALG_PI       = 3'd3,
    ALG_FIXED    = 3'd4
  } alg_t;

  // start duties, fractions of 65536
  localparam logic [15:0] DUTY_START       = 16'd39322;
  localparam logic [15:0] DUTY_AFTER_ERROR = 16'd6554;
  localparam logic [15:0] DUTY_LOW_POWER   = 16'd13107;
  localparam logic [15:0] DUTY_ZERO        = 16'd0;

  // over-voltage error bit
  localparam logic [7:0] ERR_OVER_VOLTAGE = 8'h01;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BATTERY_VOLTAGE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_WAIT_MS       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PANEL_POWER     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESCAN_HOLDOFF_MS   = 4'd3;

  // configuration reset values
  localparam logic [15:0] RST_MAX_BATTERY_VOLTAGE = 16'd15360;
  localparam logic [31:0] RST_ERROR_WAIT_MS       = 32'd1000;
  localparam logic [31:0] RST_MIN_PANEL_POWER     = 32'd65536;
  localparam logic [31:0] RST_RESCAN_HOLDOFF_MS   = 32'd10000;

  typedef struct packed {
    logic [15:0] max_battery_voltage;
    logic [31:0] error_wait_ms;
    logic [31:0] min_panel_power;
    logic [31:0] rescan_holdoff_ms;
  } cfg_t;

  // registered input item, panel power already formed
  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic [15:0] battery_voltage;
    logic [31:0] pv_power;
    logic        sweep_done;
    logic [15:0] sweep_best_duty;
    logic [7:0]  error_in;
    logic [2:0]  algorithm_code;
    logic [15:0] force_duty;
    logic        enable;
  } item_t;

  typedef struct packed {
    alg_t        algorithm;
    logic        restarted;
    logic [15:0] start_duty;
    logic        waiting;
    logic [7:0]  error_bits;
  } result_t;

  typedef struct packed {
    alg_t        algorithm;
    logic [7:0]  errors;
    logic        forced;
    logic        error_pending;
    logic [31:0] error_time;
    logic [31:0] next_rescan_time;
  } sup_state_t;

endpackage

>>> src/mas_item_if.sv
interface mas_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [15:0] battery_voltage;
  logic [15:0] panel_voltage;
  logic [15:0] panel_current;
  logic        sweep_done;
  logic [15:0] sweep_best_duty;
  logic [7:0]  error_in;
  logic [2:0]  algorithm_code;
  logic [15:0] force_duty;
  logic        enable;

  modport source (
    output valid, op, now_ms, battery_voltage, panel_voltage, panel_current,
           sweep_done, sweep_best_duty, error_in, algorithm_code, force_duty, enable,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, battery_voltage, panel_voltage, panel_current,
           sweep_done, sweep_best_duty, error_in, algorithm_code, force_duty, enable,
    output ready
  );
endinterface

>>> src/mas_result_if.sv
interface mas_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  algorithm;
  logic        restarted;
  logic [15:0] start_duty;
  logic        waiting;
  logic [7:0]  error_bits;

  modport source (
    output valid, algorithm, restarted, start_duty, waiting, error_bits,
    input  ready
  );
  modport sink (
    input  valid, algorithm, restarted, start_duty, waiting, error_bits,
    output ready
  );
endinterface

>>> src/mas_cfg_if.sv
interface mas_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mas_pkg::CFG_INDEX_W-1:0]  index;
  logic [31:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/mas_cfg_regs.sv
module mas_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  mas_cfg_if.sink        cfg,
  output mas_pkg::cfg_t  regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_battery_voltage <= mas_pkg::RST_MAX_BATTERY_VOLTAGE;
      regs.error_wait_ms       <= mas_pkg::RST_ERROR_WAIT_MS;
      regs.min_panel_power     <= mas_pkg::RST_MIN_PANEL_POWER;
      regs.rescan_holdoff_ms   <= mas_pkg::RST_RESCAN_HOLDOFF_MS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mas_pkg::CFG_MAX_BATTERY_VOLTAGE: regs.max_battery_voltage <= cfg.data[15:0];
        mas_pkg::CFG_ERROR_WAIT_MS:       regs.error_wait_ms       <= cfg.data;
        mas_pkg::CFG_MIN_PANEL_POWER:     regs.min_panel_power     <= cfg.data;
        mas_pkg::CFG_RESCAN_HOLDOFF_MS:   regs.rescan_holdoff_ms   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/mas_decide.sv
module mas_decide (
  input  mas_pkg::cfg_t       regs,
  input  mas_pkg::item_t      item,
  input  mas_pkg::sup_state_t st,
  output mas_pkg::sup_state_t st_next,
  output mas_pkg::result_t    res
);

  // one pass over the item: errors, sweep hand-over, low-power rescan, commands
  always_comb begin
    logic [31:0] elapsed;
    logic        restarted;
    logic [15:0] duty;
    st_next   = st;
    restarted = 1'b0;
    duty      = mas_pkg::DUTY_ZERO;
    elapsed   = '0;
    unique case (item.op)
      mas_pkg::OP_TICK: begin
        if (item.battery_voltage > regs.max_battery_voltage) begin
          st_next.errors = st_next.errors | mas_pkg::ERR_OVER_VOLTAGE;
        end
        // error entry forces zero duty
        if (st_next.errors != 8'd0 && !st_next.error_pending) begin
          st_next.algorithm     = mas_pkg::ALG_FIXED;
          restarted             = 1'b1;
          duty                  = mas_pkg::DUTY_ZERO;
          st_next.error_pending = 1'b1;
          st_next.error_time    = item.now_ms;
        end
        elapsed = item.now_ms - st_next.error_time;
        if (st_next.error_pending) begin
          // stabilization wait, then restart the sweep
          if (elapsed >= regs.error_wait_ms) begin
            st_next.errors        = 8'd0;
            st_next.error_pending = 1'b0;
            st_next.error_time    = '0;
            st_next.algorithm     = mas_pkg::ALG_SWEEP;
            restarted             = 1'b1;
            duty                  = mas_pkg::DUTY_AFTER_ERROR;
          end
        end else if (!st_next.forced) begin
          // sweep hand-over
          if (st_next.algorithm == mas_pkg::ALG_SWEEP && item.sweep_done) begin
            st_next.algorithm = mas_pkg::ALG_PEO;
            restarted         = 1'b1;
            duty              = item.sweep_best_duty;
          end
          // low-power rescan with holdoff
          if (item.pv_power <= regs.min_panel_power &&
              st_next.algorithm != mas_pkg::ALG_SWEEP &&
              item.now_ms >= st_next.next_rescan_time) begin
            st_next.next_rescan_time = item.now_ms + regs.rescan_holdoff_ms;
            st_next.algorithm        = mas_pkg::ALG_SWEEP;
            restarted                = 1'b1;
            duty                     = mas_pkg::DUTY_LOW_POWER;
          end
        end
      end
      mas_pkg::OP_SET_ERRORS: begin
        st_next.errors = item.error_in;
      end
      mas_pkg::OP_FORCE: begin
        if (item.algorithm_code <= mas_pkg::ALG_FIXED) begin
          st_next.algorithm = mas_pkg::alg_t'(item.algorithm_code);
          st_next.forced    = 1'b1;
          restarted         = 1'b1;
          duty              = item.force_duty;
        end
      end
      mas_pkg::OP_SET_ENABLE: begin
        if (!item.enable) begin
          st_next.algorithm = mas_pkg::ALG_FIXED;
          restarted         = 1'b1;
          duty              = mas_pkg::DUTY_ZERO;
        end else begin
          st_next.forced    = 1'b0;
          st_next.errors    = 8'd0;
          st_next.algorithm = mas_pkg::ALG_SWEEP;
          restarted         = 1'b1;
          duty              = mas_pkg::DUTY_START;
        end
      end
      default: ;
    endcase
    res.algorithm  = st_next.algorithm;
    res.restarted  = restarted;
    res.start_duty = restarted ? duty : mas_pkg::DUTY_ZERO;
    res.waiting    = st_next.error_pending;
    res.error_bits = st_next.errors;
  end

endmodule

>>> src/mppt_algorithm_supervisor.sv
// an item beat is held in the input register, then its result in the result register; a
//   stall on the result side keeps the item in the input register
// throughput: one item per cycle while results are taken, set by the single decision pass
//   whose supervisor state feeds back from the result-register edge to the next item
// reset: synchronous, active high; clears state, stage valids and loads register defaults
// no clearing pass after reset, items are taken in the first cycle after it
module mppt_algorithm_supervisor (
  input  logic          clk,
  input  logic          rst,
  mas_item_if.sink      item,
  mas_result_if.source  result,
  mas_cfg_if.sink       cfg
);

  mas_pkg::cfg_t       regs;
  mas_pkg::item_t      item_q;
  logic                item_valid;
  mas_pkg::sup_state_t st;
  mas_pkg::sup_state_t st_next;
  mas_pkg::result_t    res_next;
  mas_pkg::result_t    res_q;
  logic                res_valid;
  logic                advance;
  logic                accept;

  mas_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mas_decide u_decide (
    .regs    (regs),
    .item    (item_q),
    .st      (st),
    .st_next (st_next),
    .res     (res_next)
  );

  // stage handshake
  assign advance    = item_valid && (!res_valid || result.ready);
  assign item.ready = !item_valid || advance;
  assign accept     = item.valid && item.ready;

  // input register, panel power formed on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.op              <= mas_pkg::op_t'(item.op);
      item_q.now_ms          <= item.now_ms;
      item_q.battery_voltage <= item.battery_voltage;
      item_q.pv_power        <= 32'(item.panel_voltage) * 32'(item.panel_current);
      item_q.sweep_done      <= item.sweep_done;
      item_q.sweep_best_duty <= item.sweep_best_duty;
      item_q.error_in        <= item.error_in;
      item_q.algorithm_code  <= item.algorithm_code;
      item_q.force_duty      <= item.force_duty;
      item_q.enable          <= item.enable;
    end
  end

  // supervisor state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.algorithm        <= mas_pkg::ALG_SWEEP;
      st.errors           <= 8'd0;
      st.forced           <= 1'b0;
      st.error_pending    <= 1'b0;
      st.error_time       <= '0;
      st.next_rescan_time <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid      = res_valid;
  assign result.algorithm  = res_q.algorithm;
  assign result.restarted  = res_q.restarted;
  assign result.start_duty = res_q.start_duty;
  assign result.waiting    = res_q.waiting;
  assign result.error_bits = res_q.error_bits;

`ifndef NO_ASSERTIONS
  // a processed item always lands in the result register
  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.valid)
    else $error("processed item did not reach the result register");

  // supervisor state moves only with a processed item
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("supervisor state changed without a processed item");

  // error timer is cleared whenever no wait is pending
  a_timer_flag: assert property (@(posedge clk) disable iff (rst)
    !st.error_pending |-> st.error_time == '0)
    else $error("error timer set with no pending wait");

  // a held input item stays put while the result side stalls
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item_q))
    else $error("stalled input item was lost or changed");
`endif

endmodule

>>> bench/mas_checker.sv
`timescale 1ns / 1ps

module mas_checker (
  input  logic  clk,
  input  logic  rst,
  mas_item_if   item,
  mas_result_if result,
  mas_cfg_if    cfg,
  output int    mismatches,
  output int    pending,
  output int    results_seen,
  output int    restarts_seen,
  output int    waits_seen
);

  // supervisor copy: register settings and decision state
  mas_pkg::cfg_t   regs;
  mas_pkg::alg_t   alg_q;
  logic [7:0]      err_q;
  logic            forced_q;
  logic            pend_q;
  logic [31:0]     err_stamp_q;
  logic [31:0]     rescan_at_q;

  // expected results, oldest first
  mas_pkg::result_t expected_q[$];

  // one decision pass on the item beat now on the channel
  function automatic mas_pkg::result_t decide();
    logic             started;
    logic [15:0]      duty;
    logic [31:0]      power;
    mas_pkg::result_t r;
    started = 1'b0;
    duty    = mas_pkg::DUTY_ZERO;
    case (mas_pkg::op_t'(item.op))
      mas_pkg::OP_TICK: begin
        if (item.battery_voltage > regs.max_battery_voltage) begin
          err_q = err_q | mas_pkg::ERR_OVER_VOLTAGE;
        end
        // error entry: fixed zero duty and start the stabilization wait
        if (err_q != '0 && !pend_q) begin
          alg_q       = mas_pkg::ALG_FIXED;
          started     = 1'b1;
          duty        = mas_pkg::DUTY_ZERO;
          pend_q      = 1'b1;
          err_stamp_q = item.now_ms;
        end
        if (pend_q) begin
          // elapsed time wraps at 32 bits
          if (32'(item.now_ms - err_stamp_q) >= regs.error_wait_ms) begin
            err_q       = '0;
            pend_q      = 1'b0;
            err_stamp_q = '0;
            alg_q       = mas_pkg::ALG_SWEEP;
            started     = 1'b1;
            duty        = mas_pkg::DUTY_AFTER_ERROR;
          end
        end else if (!forced_q) begin
          // sweep hand-over to perturb-and-observe
          if (alg_q == mas_pkg::ALG_SWEEP && item.sweep_done) begin
            alg_q   = mas_pkg::ALG_PEO;
            started = 1'b1;
            duty    = item.sweep_best_duty;
          end
          // low panel power rescan, limited by the holdoff
          power = 32'(item.panel_voltage) * 32'(item.panel_current);
          if (power <= regs.min_panel_power && alg_q != mas_pkg::ALG_SWEEP &&
              item.now_ms >= rescan_at_q) begin
            rescan_at_q = item.now_ms + regs.rescan_holdoff_ms;
            alg_q       = mas_pkg::ALG_SWEEP;
            started     = 1'b1;
            duty        = mas_pkg::DUTY_LOW_POWER;
          end
        end
      end
      mas_pkg::OP_SET_ERRORS: begin
        err_q = item.error_in;
      end
      mas_pkg::OP_FORCE: begin
        if (item.algorithm_code <= mas_pkg::ALG_FIXED) begin
          alg_q    = mas_pkg::alg_t'(item.algorithm_code);
          started  = 1'b1;
          duty     = item.force_duty;
          forced_q = 1'b1;
        end
      end
      mas_pkg::OP_SET_ENABLE: begin
        if (!item.enable) begin
          alg_q   = mas_pkg::ALG_FIXED;
          started = 1'b1;
          duty    = mas_pkg::DUTY_ZERO;
        end else begin
          forced_q = 1'b0;
          err_q    = '0;
          alg_q    = mas_pkg::ALG_SWEEP;
          started  = 1'b1;
          duty     = mas_pkg::DUTY_START;
        end
      end
      default: begin
      end
    endcase
    r.algorithm  = alg_q;
    r.restarted  = started;
    r.start_duty = started ? duty : mas_pkg::DUTY_ZERO;
    r.waiting    = pend_q;
    r.error_bits = err_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 30) begin
      $display("mismatch at result %0d: %s is %0h, expected %0h",
               results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    mas_pkg::result_t want;
    if (rst) begin
      regs.max_battery_voltage = mas_pkg::RST_MAX_BATTERY_VOLTAGE;
      regs.error_wait_ms       = mas_pkg::RST_ERROR_WAIT_MS;
      regs.min_panel_power     = mas_pkg::RST_MIN_PANEL_POWER;
      regs.rescan_holdoff_ms   = mas_pkg::RST_RESCAN_HOLDOFF_MS;
      alg_q         = mas_pkg::ALG_SWEEP;
      err_q         = '0;
      forced_q      = 1'b0;
      pend_q        = 1'b0;
      err_stamp_q   = '0;
      rescan_at_q   = '0;
      expected_q.delete();
      mismatches    = 0;
      results_seen  = 0;
      restarts_seen = 0;
      waits_seen    = 0;
    end else begin
      // result beat against the oldest expectation
      if (result.valid === 1'b1 && result.ready === 1'b1) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", '0, '0);
        end else begin
          want = expected_q.pop_front();
          if (result.algorithm !== want.algorithm) begin
            report_mismatch("algorithm", 32'(result.algorithm), 32'(want.algorithm));
          end
          if (result.restarted !== want.restarted) begin
            report_mismatch("restarted", 32'(result.restarted), 32'(want.restarted));
          end
          if (result.start_duty !== want.start_duty) begin
            report_mismatch("start_duty", 32'(result.start_duty), 32'(want.start_duty));
          end
          if (result.waiting !== want.waiting) begin
            report_mismatch("waiting", 32'(result.waiting), 32'(want.waiting));
          end
          if (result.error_bits !== want.error_bits) begin
            report_mismatch("error_bits", 32'(result.error_bits), 32'(want.error_bits));
          end
          if (want.restarted) restarts_seen++;
          if (want.waiting) waits_seen++;
        end
      end
      // register write beat
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          mas_pkg::CFG_MAX_BATTERY_VOLTAGE: regs.max_battery_voltage = cfg.data[15:0];
          mas_pkg::CFG_ERROR_WAIT_MS:       regs.error_wait_ms       = cfg.data;
          mas_pkg::CFG_MIN_PANEL_POWER:     regs.min_panel_power     = cfg.data;
          mas_pkg::CFG_RESCAN_HOLDOFF_MS:   regs.rescan_holdoff_ms   = cfg.data;
          default: begin
          end
        endcase
      end
      // item beat: predict its result
      if (item.valid === 1'b1 && item.ready === 1'b1) begin
        expected_q.push_back(decide());
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> bench/tb_mppt_algorithm_supervisor.sv
`timescale 1ns / 1ps

module tb_mppt_algorithm_supervisor;

  localparam int LATENCY         = 2;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int CYCLE_LIMIT     = 400000;

  // algorithm codes the block must ignore
  localparam logic [2:0] ALG_CODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] ALG_CODE_UNUSED_HI = 3'd7;

  typedef struct {
    mas_pkg::op_t op;
    logic [31:0]  now_ms;
    logic [15:0]  battery_voltage;
    logic [15:0]  panel_voltage;
    logic [15:0]  panel_current;
    logic         sweep_done;
    logic [15:0]  sweep_best_duty;
    logic [7:0]   error_in;
    logic [2:0]   algorithm_code;
    logic [15:0]  force_duty;
    logic         enable;
  } stim_t;

  logic        clk;
  logic        rst;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [31:0] clock_ms;
  int          items_sent;
  int          settings_used;
  int          cycle_count;
  int          mismatches;
  int          pending;
  int          results_seen;
  int          restarts_seen;
  int          waits_seen;

  mas_item_if   item_ch();
  mas_result_if result_ch();
  mas_cfg_if    cfg_ch();

  mppt_algorithm_supervisor dut (
    .clk,
    .rst,
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  mas_checker supervisor_chk (
    .clk,
    .rst,
    .item          (item_ch),
    .result        (result_ch),
    .cfg           (cfg_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .results_seen  (results_seen),
    .restarts_seen (restarts_seen),
    .waits_seen    (waits_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic stim_t noise_item();
    stim_t s;
    s.op              = mas_pkg::op_t'(2'($urandom_range(3)));
    s.now_ms          = $urandom;
    s.battery_voltage = 16'($urandom);
    s.panel_voltage   = 16'($urandom);
    s.panel_current   = 16'($urandom);
    s.sweep_done      = 1'($urandom);
    s.sweep_best_duty = 16'($urandom);
    s.error_in        = 8'($urandom);
    s.algorithm_code  = 3'($urandom);
    s.force_duty      = 16'($urandom);
    s.enable          = 1'($urandom);
    return s;
  endfunction

  // mostly ticks on an advancing clock, with commands mixed in
  function automatic stim_t random_item();
    stim_t       s;
    int unsigned pick;
    s    = noise_item();
    pick = $urandom_range(99);
    if (pick < 60) begin
      s.op = mas_pkg::OP_TICK;
      pick = $urandom_range(99);
      if (pick < 70) clock_ms += $urandom_range(400);
      else if (pick < 90) clock_ms += $urandom_range(12000);
      else if (pick < 97) clock_ms += $urandom;
      s.now_ms = clock_ms;
      if ($urandom_range(99) < 80) s.battery_voltage = 16'($urandom_range(15000));
      if ($urandom_range(99) < 40) begin
        s.panel_voltage = 16'($urandom_range(300));
        s.panel_current = 16'($urandom_range(300));
      end
      s.sweep_done = ($urandom_range(99) < 30);
    end else if (pick < 70) begin
      s.op = mas_pkg::OP_SET_ERRORS;
      if ($urandom_range(99) < 40) s.error_in = '0;
    end else if (pick < 85) begin
      s.op = mas_pkg::OP_FORCE;
    end else begin
      s.op     = mas_pkg::OP_SET_ENABLE;
      s.enable = ($urandom_range(99) < 70);
    end
    return s;
  endfunction

  function automatic mas_pkg::cfg_t pick_setting(int p);
    mas_pkg::cfg_t s;
    case (p)
      0: begin
        s.max_battery_voltage = mas_pkg::RST_MAX_BATTERY_VOLTAGE;
        s.error_wait_ms       = mas_pkg::RST_ERROR_WAIT_MS;
        s.min_panel_power     = mas_pkg::RST_MIN_PANEL_POWER;
        s.rescan_holdoff_ms   = mas_pkg::RST_RESCAN_HOLDOFF_MS;
      end
      1: begin
        s = '0;
      end
      2: begin
        s = '1;
      end
      4: begin
        s.max_battery_voltage = 16'd12000;
        s.error_wait_ms       = 32'd200;
        s.min_panel_power     = 32'd4000000;
        s.rescan_holdoff_ms   = 32'd500;
      end
      default: begin
        s.max_battery_voltage = 16'($urandom_range(8000, 20000));
        s.error_wait_ms       = $urandom_range(2000);
        s.min_panel_power     = $urandom_range(200000);
        s.rescan_holdoff_ms   = $urandom_range(20000);
      end
    endcase
    return s;
  endfunction

  task automatic write_reg(logic [mas_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic load_settings(mas_pkg::cfg_t s);
    write_reg(mas_pkg::CFG_MAX_BATTERY_VOLTAGE, {16'd0, s.max_battery_voltage});
    write_reg(mas_pkg::CFG_ERROR_WAIT_MS, s.error_wait_ms);
    write_reg(mas_pkg::CFG_MIN_PANEL_POWER, s.min_panel_power);
    write_reg(mas_pkg::CFG_RESCAN_HOLDOFF_MS, s.rescan_holdoff_ms);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // one item beat, with random sender gaps ahead of it
  task automatic send_item(stim_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.op              <= s.op;
    item_ch.now_ms          <= s.now_ms;
    item_ch.battery_voltage <= s.battery_voltage;
    item_ch.panel_voltage   <= s.panel_voltage;
    item_ch.panel_current   <= s.panel_current;
    item_ch.sweep_done      <= s.sweep_done;
    item_ch.sweep_best_duty <= s.sweep_best_duty;
    item_ch.error_in        <= s.error_in;
    item_ch.algorithm_code  <= s.algorithm_code;
    item_ch.force_duty      <= s.force_duty;
    item_ch.enable          <= s.enable;
    item_ch.valid           <= 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic tick_at(logic [31:0] at, logic [15:0] vbat, logic [15:0] vpan,
                         logic [15:0] ipan, logic done, logic [15:0] best);
    stim_t s;
    s                 = noise_item();
    s.op              = mas_pkg::OP_TICK;
    s.now_ms          = at;
    s.battery_voltage = vbat;
    s.panel_voltage   = vpan;
    s.panel_current   = ipan;
    s.sweep_done      = done;
    s.sweep_best_duty = best;
    send_item(s);
  endtask

  task automatic command(mas_pkg::op_t op, logic [7:0] err, logic [2:0] code,
                         logic [15:0] duty, logic en);
    stim_t s;
    s                = noise_item();
    s.op             = op;
    s.error_in       = err;
    s.algorithm_code = code;
    s.force_duty     = duty;
    s.enable         = en;
    send_item(s);
  endtask

  // let every expected result arrive, then the pipeline settle
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // corner cases under the reset register values
  task automatic directed_checks();
    // sweep on low power: no rescan
    tick_at(32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
    // battery at the limit, hand-over then low-power rescan in one tick
    tick_at(32'd0, 16'd15360, 16'd256, 16'd256, 1'b1, 16'hFFFF);
    // hand-over at full power
    tick_at(32'd5, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'h8000);
    // low power inside the holdoff
    tick_at(32'd100, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
    // holdoff over, power exactly at threshold
    tick_at(32'd10000, 16'd0, 16'd256, 16'd256, 1'b0, 16'd0);
    // error bits from command, wait, then restart
    command(mas_pkg::OP_SET_ERRORS, 8'hFF, mas_pkg::ALG_SWEEP, 16'd0, 1'b0);
    tick_at(32'd20000, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    tick_at(32'd20999, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    tick_at(32'd21000, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    // over-voltage, commands during the wait
    tick_at(32'd30000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    command(mas_pkg::OP_SET_ERRORS, 8'h00, mas_pkg::ALG_SWEEP, 16'd0, 1'b0);
    command(mas_pkg::OP_SET_ENABLE, 8'h00, mas_pkg::ALG_SWEEP, 16'd0, 1'b1);
    tick_at(32'd31000, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    // unknown codes ignored, forcing freezes ticks
    command(mas_pkg::OP_FORCE, 8'h00, ALG_CODE_UNUSED_HI, 16'hFFFF, 1'b0);
    command(mas_pkg::OP_FORCE, 8'h00, ALG_CODE_UNUSED_LO, 16'hFFFF, 1'b0);
    command(mas_pkg::OP_FORCE, 8'h00, mas_pkg::ALG_PI, 16'h1234, 1'b0);
    tick_at(32'd40000, 16'd0, 16'd0, 16'd0, 1'b1, 16'h4321);
    command(mas_pkg::OP_SET_ENABLE, 8'h00, mas_pkg::ALG_SWEEP, 16'd0, 1'b0);
    command(mas_pkg::OP_FORCE, 8'h00, mas_pkg::ALG_DYN_STEP, 16'hFFFF, 1'b0);
    command(mas_pkg::OP_FORCE, 8'h00, mas_pkg::ALG_SWEEP, 16'h0001, 1'b0);
    command(mas_pkg::OP_FORCE, 8'h00, mas_pkg::ALG_FIXED, 16'hABCD, 1'b0);
    command(mas_pkg::OP_SET_ENABLE, 8'h00, mas_pkg::ALG_SWEEP, 16'd0, 1'b1);
    // error wait across the time stamp wrap
    command(mas_pkg::OP_SET_ERRORS, 8'h80, mas_pkg::ALG_SWEEP, 16'd0, 1'b0);
    tick_at(32'hFFFFFFF0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    tick_at(32'h000003D8, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    clock_ms = 32'h000003D8;
  endtask

  // stimulus and verdict
  initial begin
    int p;
    int k;
    rst                     = 1'b1;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    clock_ms                = '0;
    items_sent              = 0;
    settings_used           = 0;
    item_ch.valid           = 1'b0;
    item_ch.op              = mas_pkg::OP_TICK;
    item_ch.now_ms          = '0;
    item_ch.battery_voltage = '0;
    item_ch.panel_voltage   = '0;
    item_ch.panel_current   = '0;
    item_ch.sweep_done      = 1'b0;
    item_ch.sweep_best_duty = '0;
    item_ch.error_in        = '0;
    item_ch.algorithm_code  = '0;
    item_ch.force_duty      = '0;
    item_ch.enable          = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      // idling mode of this phase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      load_settings(pick_setting(p));
      if (p == 0) directed_checks();
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(random_item());
      end
      drain();
    end

    $display("covered %0d items across %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("%0d algorithm starts and %0d error-wait results predicted",
             restarts_seen, waits_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> mppt_algorithm_supervisor.f
src/mas_pkg.sv
src/mas_item_if.sv
src/mas_result_if.sv
src/mas_cfg_if.sv
src/mas_cfg_regs.sv
src/mas_decide.sv
src/mppt_algorithm_supervisor.sv
bench/mas_checker.sv
bench/tb_mppt_algorithm_supervisor.sv
